/* hdl/epq_pkg.sv */
// Shared constants, types and codes for the expiring next-hop packet queue.
package epq_pkg;

  localparam int QueueDepth = 64;
  localparam int AddrW      = $clog2(QueueDepth);
  localparam int CountW     = $clog2(QueueDepth + 1);
  localparam int LimW       = (CountW > 7) ? CountW : 7;

  typedef enum logic [2:0] {
    OP_ENQ   = 3'd0,
    OP_DEQ   = 3'd1,
    OP_TAKE  = 3'd2,
    OP_PROBE = 3'd3,
    OP_FLUSH = 3'd4
  } op_t;

  localparam logic CFG_MAX_ENTRIES = 1'b0;
  localparam logic CFG_MAX_DELAY   = 1'b1;

  typedef struct packed {
    logic accept;
    logic sweep_en;
    logic finish;
  } epq_cmd_t;

  typedef struct packed {
    logic sweep_done;
  } epq_sts_t;

endpackage

/* hdl/epq_ctrl.sv */
// Controller state machine for the packet queue: request, sweep and result sequencing.
module epq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [2:0]        in_op,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  epq_pkg::epq_sts_t sts,
  output epq_pkg::epq_cmd_t cmd
);
  import epq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SWEEP  = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_op == OP_DEQ || in_op == OP_TAKE || in_op == OP_PROBE) begin
            state_nxt = S_SWEEP;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_SWEEP: begin
        cmd.sweep_en = 1'b1;
        if (sts.sweep_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hdl/epq_dp.sv */
// Datapath for the packet queue: entry memory, compaction sweep, count and result registers.
module epq_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  epq_pkg::epq_cmd_t cmd,
  output epq_pkg::epq_sts_t sts,
  input  logic [2:0]        in_op,
  input  logic [31:0]       in_now_time,
  input  logic [31:0]       in_next_hop,
  input  logic [31:0]       in_packet_handle,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data,
  output logic              out_ok,
  output logic [31:0]       out_next_hop,
  output logic [31:0]       out_handle,
  output logic [31:0]       out_stamp,
  output logic [6:0]        out_occupancy
);
  import epq_pkg::*;

  logic [95:0] mem [QueueDepth];

  logic [6:0]        max_entries_r;
  logic [31:0]       max_delay_r;
  logic [CountW-1:0] count_r, rd_ptr_r, wr_ptr_r;
  logic              rd_valid_r, removed_r, found_r;
  logic [95:0]       rd_data_r;
  logic [2:0]        op_r;
  logic [31:0]       now_r, hop_r, handle_r;
  logic [95:0]       hit_r;

  logic              issue, keep, match, hit, wr_sweep, can_enq;
  logic [31:0]       d_hop, d_stamp;
  logic [32:0]       expiry;
  logic              mem_we;
  logic [AddrW-1:0]  mem_wa;
  logic [95:0]       mem_wd;
  logic [LimW-1:0]   cnt_ext, lim_ext;

  assign d_hop    = rd_data_r[95:64];
  assign d_stamp  = rd_data_r[31:0];

  assign issue    = cmd.sweep_en && (rd_ptr_r < count_r);
  assign expiry   = {1'b0, d_stamp} + {1'b0, max_delay_r};
  assign keep     = expiry > {1'b0, now_r};
  assign match    = (d_hop == hop_r);
  assign hit      = rd_valid_r && keep && !removed_r &&
                    (op_r == OP_DEQ || (op_r == OP_TAKE && match));
  assign wr_sweep = rd_valid_r && keep && !hit;
  assign sts.sweep_done = (rd_ptr_r == count_r) && !rd_valid_r;

  assign cnt_ext = LimW'(count_r);
  assign lim_ext = LimW'(max_entries_r);
  assign can_enq = (count_r < CountW'(QueueDepth)) && (cnt_ext < lim_ext);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = wr_ptr_r[AddrW-1:0];
    mem_wd = rd_data_r;
    if (wr_sweep) begin
      mem_we = 1'b1;
    end else if (cmd.finish && op_r == OP_ENQ && can_enq) begin
      mem_we = 1'b1;
      mem_wa = count_r[AddrW-1:0];
      mem_wd = {hop_r, handle_r, now_r};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (issue) begin
      rd_data_r <= mem[rd_ptr_r[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r     <= in_op;
      now_r    <= in_now_time;
      hop_r    <= in_next_hop;
      handle_r <= in_packet_handle;
    end
    if (cmd.accept) begin
      hit_r <= '0;
    end else if (hit) begin
      hit_r <= rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r <= 7'd64;
      max_delay_r   <= 32'd1000;
      count_r       <= '0;
      rd_ptr_r      <= '0;
      wr_ptr_r      <= '0;
      rd_valid_r    <= 1'b0;
      removed_r     <= 1'b0;
      found_r       <= 1'b0;
      out_ok        <= 1'b0;
      out_next_hop  <= '0;
      out_handle    <= '0;
      out_stamp     <= '0;
      out_occupancy <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MAX_ENTRIES: max_entries_r <= cfg_data[6:0];
          CFG_MAX_DELAY:   max_delay_r   <= cfg_data;
          default: ;
        endcase
      end
      rd_valid_r <= issue;
      if (cmd.accept) begin
        rd_ptr_r  <= '0;
        wr_ptr_r  <= '0;
        removed_r <= 1'b0;
        found_r   <= 1'b0;
      end else begin
        if (issue) begin
          rd_ptr_r <= rd_ptr_r + 1'b1;
        end
        if (wr_sweep) begin
          wr_ptr_r <= wr_ptr_r + 1'b1;
        end
        if (hit) begin
          removed_r <= 1'b1;
        end
        if (rd_valid_r && keep && match && op_r == OP_PROBE) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.finish) begin
        out_next_hop <= hit_r[95:64];
        out_handle   <= hit_r[63:32];
        out_stamp    <= hit_r[31:0];
        priority if (op_r == OP_ENQ) begin
          out_ok        <= can_enq;
          count_r       <= can_enq ? count_r + 1'b1 : count_r;
          out_occupancy <= 7'(can_enq ? count_r + 1'b1 : count_r);
        end else if (op_r == OP_DEQ || op_r == OP_TAKE || op_r == OP_PROBE) begin
          out_ok        <= removed_r || found_r;
          count_r       <= wr_ptr_r;
          out_occupancy <= 7'(wr_ptr_r);
        end else if (op_r == OP_FLUSH) begin
          out_ok        <= 1'b1;
          count_r       <= '0;
          out_occupancy <= '0;
        end else begin
          out_ok        <= 1'b0;
          out_occupancy <= 7'(count_r);
        end
      end
    end
  end

endmodule

/* hdl/expiring_next_hop_packet_queue_core.sv */
// Top level of the expiring next-hop packet queue core.
// Ordered queue of up to 64 entries with a capacity limit and age expiry.
// Enqueue, flush and unused codes go straight to the result. Dequeue,
// take and probe run one compaction sweep through the entry memory, one slot
// per cycle over its one read port and one write port, visiting every occupied
// slot. One request is in work at a time; the next is taken as soon as the
// previous result sits in the output register.
module expiring_next_hop_packet_queue_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [31:0] in_now_time,
  input  logic [31:0] in_next_hop,
  input  logic [31:0] in_packet_handle,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_ok,
  output logic [31:0] out_next_hop,
  output logic [31:0] out_handle,
  output logic [31:0] out_stamp,
  output logic [6:0]  out_occupancy,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import epq_pkg::*;

  epq_cmd_t cmd;
  epq_sts_t sts;

  assign cfg_ready = 1'b1;

  epq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  epq_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_op            (in_op),
    .in_now_time      (in_now_time),
    .in_next_hop      (in_next_hop),
    .in_packet_handle (in_packet_handle),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_ok           (out_ok),
    .out_next_hop     (out_next_hop),
    .out_handle       (out_handle),
    .out_stamp        (out_stamp),
    .out_occupancy    (out_occupancy)
  );

endmodule

/* tb/expiring_next_hop_packet_queue_core_tb.sv */
// Testbench for the expiring next-hop packet queue: directed and random requests.
module expiring_next_hop_packet_queue_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import epq_pkg::*;

  localparam int WatchdogLimit = 20000;

  typedef struct {
    logic        ok;
    logic [31:0] hop;
    logic [31:0] handle;
    logic [31:0] stamp;
    logic [6:0]  occupancy;
  } queue_result_t;

  typedef struct {
    logic [31:0] hop;
    logic [31:0] handle;
    logic [31:0] stamp;
  } queue_entry_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_op = '0;
  logic [31:0] in_now_time = '0;
  logic [31:0] in_next_hop = '0;
  logic [31:0] in_packet_handle = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_ok;
  logic [31:0] out_next_hop;
  logic [31:0] out_handle;
  logic [31:0] out_stamp;
  logic [6:0]  out_occupancy;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  queue_entry_t  model_queue[$];
  queue_result_t pending_results[$];
  logic [6:0]    model_max_entries = 7'd64;
  logic [31:0]   model_max_delay = 32'd1000;
  logic [31:0]   clock_now = 32'd0;
  int            error_count = 0;
  int            idle_cycles = 0;
  int            burst_left = 0;
  int            stall_mode = 0;

  expiring_next_hop_packet_queue_core DUT (.*);

  always #2 clk = ~clk;

  function automatic void purge_expired(logic [31:0] now);
    queue_entry_t kept[$];
    foreach (model_queue[k])
      if ({1'b0, model_queue[k].stamp} + {1'b0, model_max_delay} > {1'b0, now})
        kept = {kept, model_queue[k]};
    model_queue = kept;
  endfunction

  function automatic queue_result_t predict_queue(logic [2:0] op, logic [31:0] now,
                                                  logic [31:0] hop, logic [31:0] handle);
    queue_result_t r;
    int limit;
    queue_entry_t e;
    r = '{1'b0, 32'd0, 32'd0, 32'd0, 7'd0};
    limit = (model_max_entries < QueueDepth) ? model_max_entries : QueueDepth;
    case (op)
      OP_ENQ: begin
        if (model_queue.size() < limit) begin
          e.hop = hop;
          e.handle = handle;
          e.stamp = now;
          model_queue = {model_queue, e};
          r.ok = 1'b1;
        end
      end
      OP_DEQ: begin
        purge_expired(now);
        if (model_queue.size() > 0) begin
          e = model_queue.pop_front();
          r = '{1'b1, e.hop, e.handle, e.stamp, 7'd0};
        end
      end
      OP_TAKE, OP_PROBE: begin
        purge_expired(now);
        foreach (model_queue[k]) begin
          if (!r.ok && model_queue[k].hop == hop) begin
            r.ok = 1'b1;
            if (op == OP_TAKE) begin
              e = model_queue[k];
              r.hop = e.hop;
              r.handle = e.handle;
              r.stamp = e.stamp;
              model_queue.delete(k);
              break;
            end
          end
        end
      end
      OP_FLUSH: begin
        model_queue.delete();
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.occupancy = 7'(model_queue.size());
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 2) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    queue_result_t exp_r;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WatchdogLimit) begin
        $display("expiring_next_hop_packet_queue_core_tb NOT OK");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result with no request waiting");
          error_count++;
        end else begin
          exp_r = pending_results.pop_front();
          if (out_ok !== exp_r.ok) begin
            $error("ok exp %0h got %0h", exp_r.ok, out_ok);
            error_count++;
          end
          if (out_next_hop !== exp_r.hop) begin
            $error("next_hop exp %0h got %0h", exp_r.hop, out_next_hop);
            error_count++;
          end
          if (out_handle !== exp_r.handle) begin
            $error("handle exp %0h got %0h", exp_r.handle, out_handle);
            error_count++;
          end
          if (out_stamp !== exp_r.stamp) begin
            $error("stamp exp %0h got %0h", exp_r.stamp, out_stamp);
            error_count++;
          end
          if (out_occupancy !== exp_r.occupancy) begin
            $error("occupancy exp %0d got %0d", exp_r.occupancy, out_occupancy);
            error_count++;
          end
        end
      end
    end
  end

  task automatic send_request(logic [2:0] op, logic [31:0] now, logic [31:0] hop,
                              logic [31:0] handle);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_op <= op;
    in_now_time <= now;
    in_next_hop <= hop;
    in_packet_handle <= handle;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results = {pending_results, predict_queue(op, now, hop, handle)};
  endtask

  task automatic write_register(logic index, logic [31:0] data);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (index == CFG_MAX_ENTRIES)
      model_max_entries = data[6:0];
    else
      model_max_delay = data;
  endtask

  task automatic test_directed();
    send_request(OP_DEQ, 32'd0, 32'd0, 32'd0);
    send_request(OP_ENQ, 32'd0, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_request(OP_ENQ, 32'd5, 32'd0, 32'hA5A5A5A5);
    send_request(OP_ENQ, 32'd10, 32'h0A000001, 32'd3);
    send_request(OP_PROBE, 32'd20, 32'h0A000001, 32'd0);
    send_request(OP_PROBE, 32'd20, 32'h0A000002, 32'd0);
    send_request(OP_TAKE, 32'd20, 32'h0A000001, 32'd0);
    send_request(OP_TAKE, 32'd20, 32'h0A000009, 32'd0);
    send_request(OP_DEQ, 32'd999, 32'd0, 32'd0);
    send_request(OP_DEQ, 32'd1005, 32'd0, 32'd0);
    send_request(OP_DEQ, 32'd1005, 32'd0, 32'd0);
    send_request(3'd5, 32'd1, 32'd1, 32'd1);
    send_request(3'd6, 32'd1, 32'd1, 32'd1);
    send_request(3'd7, 32'hFFFFFFFF, 32'd1, 32'd1);
    send_request(OP_ENQ, 32'hFFFFFF00, 32'd7, 32'd7);
    send_request(OP_PROBE, 32'hFFFFFFFF, 32'd7, 32'd0);
    send_request(OP_FLUSH, 32'd0, 32'd0, 32'd0);
    send_request(OP_DEQ, 32'hFFFFFFFF, 32'd0, 32'd0);
  endtask

  task automatic test_capacity();
    write_register(CFG_MAX_ENTRIES, 32'd0);
    send_request(OP_ENQ, 32'd1, 32'd1, 32'd1);
    write_register(CFG_MAX_ENTRIES, 32'd3);
    repeat (5) send_request(OP_ENQ, 32'd2, $urandom, $urandom);
    send_request(OP_FLUSH, 32'd0, 32'd0, 32'd0);
    write_register(CFG_MAX_ENTRIES, 32'd127);
    repeat (66) send_request(OP_ENQ, 32'd3, $urandom_range(0, 3), $urandom);
    send_request(OP_TAKE, 32'd3, 32'd2, 32'd0);
    send_request(OP_DEQ, 32'd3, 32'd0, 32'd0);
    send_request(OP_FLUSH, 32'd0, 32'd0, 32'd0);
  endtask

  task automatic run_random_phase(int count);
    logic [2:0] op;
    logic [31:0] hop;
    int sel;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) op = OP_ENQ;
      else if (sel < 58) op = OP_DEQ;
      else if (sel < 75) op = OP_TAKE;
      else if (sel < 90) op = OP_PROBE;
      else if (sel < 94) op = OP_FLUSH;
      else op = 3'($urandom_range(5, 7));
      clock_now = clock_now + $urandom_range(0, 40);
      hop = ($urandom_range(0, 4) == 0) ? $urandom : 32'($urandom_range(0, 7));
      send_request(op, clock_now, hop, $urandom);
    end
  endtask

  task automatic test_random();
    stall_mode = 0;
    write_register(CFG_MAX_DELAY, 32'd300);
    run_random_phase(150);
    stall_mode = 1;
    write_register(CFG_MAX_ENTRIES, 32'd8);
    write_register(CFG_MAX_DELAY, 32'd0);
    run_random_phase(100);
    stall_mode = 2;
    write_register(CFG_MAX_ENTRIES, 32'd64);
    write_register(CFG_MAX_DELAY, 32'hFFFFFFFF);
    run_random_phase(150);
    clock_now = 32'hFFFF0000;
    stall_mode = 1;
    write_register(CFG_MAX_DELAY, 32'd100);
    run_random_phase(150);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_capacity();
    test_random();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (error_count == 0)
      $display("expiring_next_hop_packet_queue_core_tb OK");
    else
      $display("expiring_next_hop_packet_queue_core_tb NOT OK");
    $finish;
  end
endmodule
